// File: rtl/core/mcfp_pkg.sv
// shared constants and decimal helpers for the motor command frame parser
package mcfp_pkg;

  // header and function bytes
  localparam logic [7:0] HDR0_BYTE   = 8'd49;
  localparam logic [7:0] HDR1_BYTE   = 8'd55;
  localparam logic [7:0] HDR2_BYTE   = 8'd48;
  localparam logic [7:0] FN_MOTOR    = 8'd109;
  localparam logic [7:0] FN_SERVO    = 8'd115;
  localparam logic [7:0] FN_STOP     = 8'd112;
  localparam logic [7:0] DIGIT_BASE  = 8'd48;

  // frame shape
  localparam int PAYLOAD_LEN = 9;
  localparam int STOP_LEN    = 4;

  // result constants
  localparam logic [15:0] MOTOR_ID    = 16'hEE00;
  localparam logic [15:0] SERVO_ID    = 16'h1200;
  localparam logic [18:0] SERVO_SPEED = 19'd110;
  localparam logic        KIND_MOTOR  = 1'b0;
  localparam logic        KIND_SERVO  = 1'b1;

  // field widths
  localparam int DIST_W  = 22;
  localparam int SPEED_W = 19;

  typedef logic [7:0] digit_t;

  // four digits weighted 1000, 100, 10, 1
  function automatic logic [18:0] dec4(digit_t a, digit_t b, digit_t c, digit_t d);
    logic [18:0] sum;
    sum = 19'(a) * 19'd1000 + 19'(b) * 19'd100 + 19'(c) * 19'd10 + 19'(d);
    return sum;
  endfunction

  // three digits weighted 100, 10, 1, then scaled by 100
  function automatic logic [21:0] dec3_x100(digit_t a, digit_t b, digit_t c);
    logic [14:0] whole;
    whole = 15'(a) * 15'd100 + 15'(b) * 15'd10 + 15'(c);
    return 22'(whole) * 22'd100;
  endfunction

endpackage

// File: rtl/core/motor_command_frame_parser.sv
// motor command frame parser: header hunt, payload collection, result register
// pipeline: a byte accepted is held in the input register and parsed from there; a frame
//   result is valid from the cycle after its ninth payload byte is parsed
// throughput: one byte per cycle when not stalled, set by the input register feeding the parser
// a waiting result stalls only the byte that would complete the next frame
// reset: rst_n low clears phase, count and both valid flags; digit store is not reset
module motor_command_frame_parser (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_rx_byte,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_frame_kind,
  output logic [7:0]                     out_direction,
  output logic [mcfp_pkg::DIST_W-1:0]    out_distance_hundredths,
  output logic [mcfp_pkg::SPEED_W-1:0]   out_speed_hundredths,
  output logic [15:0]                    out_bus_id
);
  import mcfp_pkg::*;

  // parse phases
  localparam logic [2:0] PH_HDR0  = 3'd0;
  localparam logic [2:0] PH_HDR1  = 3'd1;
  localparam logic [2:0] PH_HDR2  = 3'd2;
  localparam logic [2:0] PH_FUNC  = 3'd3;
  localparam logic [2:0] PH_MOTOR = 3'd4;
  localparam logic [2:0] PH_SERVO = 3'd5;
  localparam logic [2:0] PH_STOP  = 3'd6;

  localparam logic [3:0] LAST_DIGIT = 4'(PAYLOAD_LEN - 1);
  localparam logic [3:0] LAST_STOP  = 4'(STOP_LEN - 1);

  logic                hold_valid_r;
  logic [7:0]          hold_byte_r;
  logic [2:0]          phase_r, phase_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  digit_t              digits_r [PAYLOAD_LEN];
  digit_t              digit;
  logic                in_payload;
  logic                emits;
  logic                adv;
  logic                load;

  logic                out_valid_r, out_valid_nxt;
  logic                kind_r;
  logic [7:0]          dir_r;
  logic [DIST_W-1:0]   dist_r;
  logic [SPEED_W-1:0]  speed_r;
  logic [15:0]         id_r;

  // handshake and stall control
  assign digit      = hold_byte_r - DIGIT_BASE;
  assign in_payload = (phase_r == PH_MOTOR) || (phase_r == PH_SERVO);
  assign emits      = hold_valid_r && in_payload && (cnt_r == LAST_DIGIT);
  assign adv        = hold_valid_r && (!emits || !out_valid_r || out_ready);
  assign load       = emits && adv;
  assign in_ready   = !hold_valid_r || adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else if (in_ready) begin
      hold_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      hold_byte_r <= in_rx_byte;
    end
  end

  // phase and count update
  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    case (phase_r)
      PH_HDR0: phase_nxt = (hold_byte_r == HDR0_BYTE) ? PH_HDR1 : PH_HDR0;
      PH_HDR1: phase_nxt = (hold_byte_r == HDR1_BYTE) ? PH_HDR2 : PH_HDR0;
      PH_HDR2: phase_nxt = (hold_byte_r == HDR2_BYTE) ? PH_FUNC : PH_HDR0;
      PH_FUNC: begin
        cnt_nxt = 4'd0;
        if (hold_byte_r == FN_MOTOR) begin
          phase_nxt = PH_MOTOR;
        end else if (hold_byte_r == FN_SERVO) begin
          phase_nxt = PH_SERVO;
        end else if (hold_byte_r == FN_STOP) begin
          phase_nxt = PH_STOP;
        end else begin
          phase_nxt = PH_HDR0;
        end
      end
      PH_MOTOR, PH_SERVO: begin
        if (cnt_r == LAST_DIGIT) begin
          phase_nxt = PH_HDR0;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      PH_STOP: begin
        if (cnt_r == LAST_STOP) begin
          phase_nxt = PH_HDR0;
          cnt_nxt   = 4'd0;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: begin
        phase_nxt = PH_HDR0;
        cnt_nxt   = 4'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HDR0;
      cnt_r   <= 4'd0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // digit store
  always_ff @(posedge clk) begin
    if (adv && in_payload && (cnt_r < LAST_DIGIT)) begin
      digits_r[cnt_r] <= digit;
    end
  end

  // result register
  always_comb begin
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (phase_r == PH_MOTOR) begin
        kind_r  <= KIND_MOTOR;
        dir_r   <= digits_r[0];
        dist_r  <= DIST_W'(dec4(digits_r[1], digits_r[2], digits_r[3], digits_r[4]));
        speed_r <= dec4(digits_r[5], digits_r[6], digits_r[7], digit);
        id_r    <= MOTOR_ID;
      end else begin
        kind_r  <= KIND_SERVO;
        dir_r   <= digits_r[3];
        dist_r  <= dec3_x100(digits_r[0], digits_r[1], digits_r[2]);
        speed_r <= SERVO_SPEED;
        id_r    <= SERVO_ID;
      end
    end
  end

  assign out_valid               = out_valid_r;
  assign out_frame_kind          = kind_r;
  assign out_direction           = dir_r;
  assign out_distance_hundredths = dist_r;
  assign out_speed_hundredths    = speed_r;
  assign out_bus_id              = id_r;

`ifndef SYNTH
  // stop payload count stays below its length
  a_stop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_STOP) |-> (cnt_r <= LAST_STOP))
    else $error("stop payload count out of range");

  // collection count stays within the store
  a_payload_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_payload |-> (cnt_r <= LAST_DIGIT))
    else $error("payload count out of range");

  // a loaded result sends the parser back to the hunt
  a_hunt_after: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (phase_r == PH_HDR0) && out_valid_r)
    else $error("parser not back in hunt after result");

  // a result only appears after a completing payload byte
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(load))
    else $error("result appeared without a completed frame");

  // id matches the frame kind
  a_id_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((kind_r == KIND_MOTOR && id_r == MOTOR_ID) ||
                     (kind_r == KIND_SERVO && id_r == SERVO_ID)))
    else $error("bus id does not match frame kind");
`endif

endmodule
